>>> rtl/bmm_pkg.sv
// Shared types and constants of the barycentric mesh morph block.
package bmm_pkg;

   localparam int LOW_VERTS   = 4096;
   localparam int IDX_BITS    = $clog2(LOW_VERTS);
   localparam int COORD_BITS  = 32;
   localparam int QDEPTH      = 2;
   localparam int Q_PTR_BITS  = $clog2(QDEPTH);
   localparam int Q_CNT_BITS  = $clog2(QDEPTH + 1);

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_MORPH = 1'b1;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef coord_type [2:0] vec_type;

   typedef struct packed {
      logic [IDX_BITS-1:0] dest;
      coord_type           w0;
      coord_type           w1;
      coord_type           w2;
      coord_type           d;
      vec_type             a;
      vec_type             b;
      vec_type             c;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef enum logic [1:0] {
      FE_IDLE,
      FE_RD_B,
      FE_RD_C,
      FE_PUSH
   } fe_state_type;

   typedef enum logic [3:0] {
      BE_IDLE,
      BE_DIFF,
      BE_CROSS,
      BE_NORM,
      BE_SQUARE,
      BE_SQRT,
      BE_DIV_INIT,
      BE_DIV_RUN,
      BE_MAC,
      BE_OUT
   } be_state_type;

endpackage

>>> rtl/bmm_front.sv
// Front end: accepts requests, owns the vertex store, fetches the three source vertices.
module bmm_front import bmm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                req_command,
   input  logic [IDX_BITS-1:0] req_target_index,
   input  coord_type           req_pos_x,
   input  coord_type           req_pos_y,
   input  coord_type           req_pos_z,
   input  coord_type           req_weight_zero,
   input  coord_type           req_weight_one,
   input  coord_type           req_weight_two,
   input  coord_type           req_normal_offset,
   input  logic [IDX_BITS-1:0] req_src_a,
   input  logic [IDX_BITS-1:0] req_src_b,
   input  logic [IDX_BITS-1:0] req_src_c,
   input  q_status_type        q_status,
   output logic                busy,
   output logic                push,
   output job_type             push_job
);

   fe_state_type        state_ff, state_in;
   job_type             job_ff, job_in;
   logic [IDX_BITS-1:0] src_b_ff, src_b_in, src_c_ff, src_c_in, rd_addr;
   coord_type           store_x_ff [LOW_VERTS];
   coord_type           store_y_ff [LOW_VERTS];
   coord_type           store_z_ff [LOW_VERTS];
   coord_type           rd_x_ff, rd_y_ff, rd_z_ff;
   logic                accept, wr_en;

   assign busy   = (state_ff != FE_IDLE) || q_status.full;
   assign accept = start && !busy;
   assign wr_en  = accept && (req_command == CMD_LOAD);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FE_IDLE: begin
            if (accept && (req_command == CMD_MORPH)) state_in = FE_RD_B;
         end
         FE_RD_B: state_in = FE_RD_C;
         FE_RD_C: state_in = FE_PUSH;
         FE_PUSH: state_in = FE_IDLE;
         default: state_in = FE_IDLE;
      endcase
   end

   always_comb begin
      job_in   = job_ff;
      src_b_in = src_b_ff;
      src_c_in = src_c_ff;
      rd_addr  = req_src_a;
      push     = 1'b0;
      push_job = job_ff;
      unique case (state_ff)
         FE_IDLE: begin
            rd_addr = req_src_a;
            if (accept) begin
               job_in.dest = req_target_index;
               job_in.w0   = req_weight_zero;
               job_in.w1   = req_weight_one;
               job_in.w2   = req_weight_two;
               job_in.d    = req_normal_offset;
               src_b_in    = req_src_b;
               src_c_in    = req_src_c;
            end
         end
         FE_RD_B: begin
            rd_addr     = src_b_ff;
            job_in.a[0] = rd_x_ff;
            job_in.a[1] = rd_y_ff;
            job_in.a[2] = rd_z_ff;
         end
         FE_RD_C: begin
            rd_addr     = src_c_ff;
            job_in.b[0] = rd_x_ff;
            job_in.b[1] = rd_y_ff;
            job_in.b[2] = rd_z_ff;
         end
         FE_PUSH: begin
            rd_addr       = src_c_ff;
            push          = 1'b1;
            push_job.c[0] = rd_x_ff;
            push_job.c[1] = rd_y_ff;
            push_job.c[2] = rd_z_ff;
         end
         default: rd_addr = req_src_a;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FE_IDLE;
      end else begin
         state_ff <= state_in;
      end
      job_ff   <= job_in;
      src_b_ff <= src_b_in;
      src_c_ff <= src_c_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_x_ff[req_target_index] <= req_pos_x;
         store_y_ff[req_target_index] <= req_pos_y;
         store_z_ff[req_target_index] <= req_pos_z;
      end
      rd_x_ff <= store_x_ff[rd_addr];
      rd_y_ff <= store_y_ff[rd_addr];
      rd_z_ff <= store_z_ff[rd_addr];
   end

endmodule

>>> rtl/bmm_queue.sv
// Short job queue between the fetch front end and the arithmetic back end.
module bmm_queue import bmm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  job_type      push_job,
   input  logic         pop,
   output job_type      head,
   output q_status_type q_status
);

   job_type               slot_ff [QDEPTH];
   logic [Q_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_BITS-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign q_status.full  = (count_ff == Q_CNT_BITS'(QDEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_push        = push && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign head           = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_BITS'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_BITS'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) slot_ff[wr_ptr_ff] <= push_job;
   end

endmodule

>>> rtl/bmm_back.sv
// Back end: cross product, normalization, square root, division and weighted sum.
module bmm_back import bmm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  job_type             head,
   input  q_status_type        q_status,
   output logic                pop,
   output logic                rsp_valid,
   output logic [IDX_BITS-1:0] rsp_dest_index,
   output coord_type           rsp_out_x,
   output coord_type           rsp_out_y,
   output coord_type           rsp_out_z,
   output logic                rsp_degenerate,
   output logic                rsp_saturated
);

   be_state_type       state_ff, state_in;
   job_type            job_ff, job_in;
   logic signed [30:0] v1_ff [3], v1_in [3], v2_ff [3], v2_in [3];
   logic signed [65:0] acc_ff, acc_in, acc_new, prod_x, rnd;
   logic signed [63:0] prod_ff, prod_in;
   logic               phase_ff, phase_in;
   logic [3:0]         cnt_ff, cnt_in;
   logic [61:0]        crm_ff [3], crm_in [3];
   logic               crs_ff [3], crs_in [3];
   logic [63:0]        rt_v_ff, rt_v_in, rt_res_ff, rt_res_in, bitv, trial_rt;
   logic [4:0]         rt_k_ff, rt_k_in;
   logic [31:0]        root_ff, root_in, rem_ff, rem_in, trial_dv;
   logic [20:0]        nlow_ff, nlow_in, quo_ff, quo_in, quo_new;
   logic [4:0]         dk_ff, dk_in;
   logic [20:0]        nq_ff [3], nq_in [3];
   coord_type          out_ff [3], out_in [3];
   logic               degen_ff, degen_in, sat_ff, sat_in;
   logic signed [31:0] mul_a, mul_b, n_sel;
   logic signed [32:0] d1_w [3], d2_w [3];
   logic [32:0]        m1_w [3], m2_w [3], or_w, t1_w, t2_w;
   logic [1:0]         shift_w, j, i1, i2, axis;
   logic [61:0]        orv;
   logic [65:0]        cr_mag;
   logic [46:0]        num;

   assign pop            = (state_ff == BE_IDLE) && !q_status.empty;
   assign rsp_valid      = (state_ff == BE_OUT);
   assign rsp_dest_index = job_ff.dest;
   assign rsp_out_x      = out_ff[0];
   assign rsp_out_y      = out_ff[1];
   assign rsp_out_z      = out_ff[2];
   assign rsp_degenerate = degen_ff;
   assign rsp_saturated  = sat_ff;

   // edge differences and their common prescale
   always_comb begin
      or_w = '0;
      for (int i = 0; i < 3; i++) begin
         d1_w[i] = 33'(job_ff.a[i]) - 33'(job_ff.b[i]);
         d2_w[i] = 33'(job_ff.c[i]) - 33'(job_ff.b[i]);
         m1_w[i] = d1_w[i][32] ? 33'(-d1_w[i]) : 33'(d1_w[i]);
         m2_w[i] = d2_w[i][32] ? 33'(-d2_w[i]) : 33'(d2_w[i]);
         or_w    = or_w | m1_w[i] | m2_w[i];
      end
      if (or_w[32])      shift_w = 2'd3;
      else if (or_w[31]) shift_w = 2'd2;
      else if (or_w[30]) shift_w = 2'd1;
      else               shift_w = 2'd0;
   end

   assign j    = cnt_ff[2:1];
   assign axis = cnt_ff[3:2];
   always_comb begin
      case (j)
         2'd0:    begin i1 = 2'd1; i2 = 2'd2; end
         2'd1:    begin i1 = 2'd2; i2 = 2'd0; end
         default: begin i1 = 2'd0; i2 = 2'd1; end
      endcase
   end

   assign n_sel = crs_ff[axis] ? -$signed({11'd0, nq_ff[axis]}) : $signed({11'd0, nq_ff[axis]});

   // operand select for the shared multiplier
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         BE_CROSS: begin
            if (!cnt_ff[0]) begin
               mul_a = 32'(v1_ff[i1]);
               mul_b = 32'(v2_ff[i2]);
            end else begin
               mul_a = 32'(v1_ff[i2]);
               mul_b = 32'(v2_ff[i1]);
            end
         end
         BE_SQUARE: begin
            mul_a = $signed({2'd0, crm_ff[cnt_ff[1:0]][29:0]});
            mul_b = $signed({2'd0, crm_ff[cnt_ff[1:0]][29:0]});
         end
         BE_MAC: begin
            case (cnt_ff[1:0])
               2'd0:    begin mul_a = job_ff.w2; mul_b = job_ff.a[axis]; end
               2'd1:    begin mul_a = job_ff.w1; mul_b = job_ff.b[axis]; end
               2'd2:    begin mul_a = job_ff.w0; mul_b = job_ff.c[axis]; end
               default: begin mul_a = job_ff.d;  mul_b = n_sel;          end
            endcase
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in  = mul_a * mul_b;
   assign prod_x   = 66'(prod_ff);
   assign orv      = crm_ff[0] | crm_ff[1] | crm_ff[2];
   assign bitv     = 64'd1 << {rt_k_ff, 1'b0};
   assign trial_rt = rt_res_ff + bitv;
   assign trial_dv = {rem_ff[30:0], nlow_ff[20]};
   assign num      = {1'b0, crm_ff[cnt_ff[1:0]][29:0], 16'd0} + {16'd0, root_ff[31:1]};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BE_IDLE:     if (!q_status.empty) state_in = BE_DIFF;
         BE_DIFF:     state_in = BE_CROSS;
         BE_CROSS:    if (phase_ff && cnt_ff == 4'd5) state_in = BE_NORM;
         BE_NORM: begin
            if (orv == '0)                         state_in = BE_MAC;
            else if (orv[61:30] == '0 && orv[29]) state_in = BE_SQUARE;
         end
         BE_SQUARE:   if (phase_ff && cnt_ff == 4'd2) state_in = BE_SQRT;
         BE_SQRT:     if (rt_k_ff == '0) state_in = BE_DIV_INIT;
         BE_DIV_INIT: state_in = BE_DIV_RUN;
         BE_DIV_RUN: begin
            if (dk_ff == '0) state_in = (cnt_ff == 4'd2) ? BE_MAC : BE_DIV_INIT;
         end
         BE_MAC:      if (phase_ff && cnt_ff == 4'd11) state_in = BE_OUT;
         BE_OUT:      state_in = BE_IDLE;
         default:     state_in = BE_IDLE;
      endcase
   end

   always_comb begin
      job_in    = job_ff;
      acc_in    = acc_ff;
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      rt_v_in   = rt_v_ff;
      rt_res_in = rt_res_ff;
      rt_k_in   = rt_k_ff;
      root_in   = root_ff;
      rem_in    = rem_ff;
      nlow_in   = nlow_ff;
      quo_in    = quo_ff;
      dk_in     = dk_ff;
      degen_in  = degen_ff;
      sat_in    = sat_ff;
      acc_new   = acc_ff;
      cr_mag    = '0;
      rnd       = '0;
      quo_new   = quo_ff;
      t1_w      = '0;
      t2_w      = '0;
      for (int i = 0; i < 3; i++) begin
         v1_in[i]  = v1_ff[i];
         v2_in[i]  = v2_ff[i];
         crm_in[i] = crm_ff[i];
         crs_in[i] = crs_ff[i];
         nq_in[i]  = nq_ff[i];
         out_in[i] = out_ff[i];
      end
      case (state_ff)
         BE_IDLE: begin
            if (!q_status.empty) begin
               job_in   = head;
               degen_in = 1'b0;
               sat_in   = 1'b0;
            end
         end
         BE_DIFF: begin
            for (int i = 0; i < 3; i++) begin
               t1_w     = m1_w[i] >> shift_w;
               t2_w     = m2_w[i] >> shift_w;
               t1_w     = d1_w[i][32] ? 33'(-t1_w) : t1_w;
               t2_w     = d2_w[i][32] ? 33'(-t2_w) : t2_w;
               v1_in[i] = t1_w[30:0];
               v2_in[i] = t2_w[30:0];
            end
            cnt_in   = '0;
            phase_in = 1'b0;
         end
         BE_CROSS: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               acc_new = cnt_ff[0] ? acc_ff - prod_x : prod_x;
               acc_in  = acc_new;
               if (cnt_ff[0]) begin
                  cr_mag    = acc_new[65] ? 66'(-acc_new) : 66'(acc_new);
                  crm_in[j] = cr_mag[61:0];
                  crs_in[j] = acc_new[65];
               end
               cnt_in = (cnt_ff == 4'd5) ? '0 : cnt_ff + 1'b1;
            end
         end
         BE_NORM: begin
            if (orv == '0) begin
               degen_in = 1'b1;
               cnt_in   = '0;
               phase_in = 1'b0;
               for (int i = 0; i < 3; i++) nq_in[i] = '0;
            end else if (orv[61:30] != '0) begin
               // shrink magnitudes; sign kept apart, so this truncates toward zero
               for (int i = 0; i < 3; i++) crm_in[i] = crm_ff[i] >> 1;
            end else if (!orv[29]) begin
               for (int i = 0; i < 3; i++) crm_in[i] = crm_ff[i] << 1;
            end else begin
               cnt_in   = '0;
               phase_in = 1'b0;
            end
         end
         BE_SQUARE: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               acc_new = (cnt_ff == '0) ? prod_x : acc_ff + prod_x;
               acc_in  = acc_new;
               cnt_in  = cnt_ff + 1'b1;
               if (cnt_ff == 4'd2) begin
                  rt_v_in   = acc_new[63:0];
                  rt_res_in = '0;
                  rt_k_in   = 5'd31;
               end
            end
         end
         BE_SQRT: begin
            if (rt_v_ff >= trial_rt) begin
               rt_v_in   = rt_v_ff - trial_rt;
               rt_res_in = (rt_res_ff >> 1) + bitv;
            end else begin
               rt_res_in = rt_res_ff >> 1;
            end
            rt_k_in = rt_k_ff - 1'b1;
            if (rt_k_ff == '0) begin
               root_in = rt_res_in[31:0];
               cnt_in  = '0;
            end
         end
         BE_DIV_INIT: begin
            rem_in  = {6'd0, num[46:21]};
            nlow_in = num[20:0];
            quo_in  = '0;
            dk_in   = 5'd20;
         end
         BE_DIV_RUN: begin
            if (trial_dv >= root_ff) begin
               rem_in  = trial_dv - root_ff;
               quo_new = {quo_ff[19:0], 1'b1};
            end else begin
               rem_in  = trial_dv;
               quo_new = {quo_ff[19:0], 1'b0};
            end
            quo_in  = quo_new;
            nlow_in = nlow_ff << 1;
            dk_in   = dk_ff - 1'b1;
            if (dk_ff == '0) begin
               nq_in[cnt_ff[1:0]] = quo_new;
               cnt_in   = (cnt_ff == 4'd2) ? '0 : cnt_ff + 1'b1;
               phase_in = 1'b0;
            end
         end
         BE_MAC: begin
            phase_in = !phase_ff;
            if (phase_ff) begin
               acc_new = (cnt_ff[1:0] == 2'd0) ? prod_x : acc_ff + prod_x;
               acc_in  = acc_new;
               cnt_in  = cnt_ff + 1'b1;
               if (cnt_ff[1:0] == 2'd3) begin
                  // round half up, then clamp
                  rnd = (acc_new + 66'sd32768) >>> 16;
                  if (rnd > 66'sd2147483647) begin
                     out_in[axis] = 32'sh7FFFFFFF;
                     sat_in       = 1'b1;
                  end else if (rnd < -66'sd2147483648) begin
                     out_in[axis] = 32'sh80000000;
                     sat_in       = 1'b1;
                  end else begin
                     out_in[axis] = rnd[31:0];
                  end
               end
            end
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BE_IDLE;
      end else begin
         state_ff <= state_in;
      end
      job_ff    <= job_in;
      acc_ff    <= acc_in;
      prod_ff   <= prod_in;
      phase_ff  <= phase_in;
      cnt_ff    <= cnt_in;
      rt_v_ff   <= rt_v_in;
      rt_res_ff <= rt_res_in;
      rt_k_ff   <= rt_k_in;
      root_ff   <= root_in;
      rem_ff    <= rem_in;
      nlow_ff   <= nlow_in;
      quo_ff    <= quo_in;
      dk_ff     <= dk_in;
      degen_ff  <= degen_in;
      sat_ff    <= sat_in;
      for (int i = 0; i < 3; i++) begin
         v1_ff[i]  <= v1_in[i];
         v2_ff[i]  <= v2_in[i];
         crm_ff[i] <= crm_in[i];
         crs_ff[i] <= crs_in[i];
         nq_ff[i]  <= nq_in[i];
         out_ff[i] <= out_in[i];
      end
   end

endmodule

>>> rtl/barycentric_mesh_morph.sv
// Load request: written into the vertex store, no result.
// Morph request: the front end is busy fetching a, b and c, then queues the job.
// The back end works on one morph at a time and normalizes the cross product in shift steps;
// a flat triangle skips the root and division. Its one multiplier and bit-serial root and
// divider set the throughput; the queue holds two jobs.
// Synchronous reset clears control state; the vertex store is undefined until written.
module barycentric_mesh_morph import bmm_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_command,
   input  logic [IDX_BITS-1:0] req_target_index,
   input  coord_type           req_pos_x,
   input  coord_type           req_pos_y,
   input  coord_type           req_pos_z,
   input  coord_type           req_weight_zero,
   input  coord_type           req_weight_one,
   input  coord_type           req_weight_two,
   input  coord_type           req_normal_offset,
   input  logic [IDX_BITS-1:0] req_src_a,
   input  logic [IDX_BITS-1:0] req_src_b,
   input  logic [IDX_BITS-1:0] req_src_c,
   output logic                rsp_valid,
   output logic [IDX_BITS-1:0] rsp_dest_index,
   output coord_type           rsp_out_x,
   output coord_type           rsp_out_y,
   output coord_type           rsp_out_z,
   output logic                rsp_degenerate,
   output logic                rsp_saturated
);

   q_status_type q_status;
   job_type      push_job, head;
   logic         push, pop;

   bmm_front u_front (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .req_command       (req_command),
      .req_target_index  (req_target_index),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_pos_z         (req_pos_z),
      .req_weight_zero   (req_weight_zero),
      .req_weight_one    (req_weight_one),
      .req_weight_two    (req_weight_two),
      .req_normal_offset (req_normal_offset),
      .req_src_a         (req_src_a),
      .req_src_b         (req_src_b),
      .req_src_c         (req_src_c),
      .q_status          (q_status),
      .busy              (busy),
      .push              (push),
      .push_job          (push_job)
   );

   bmm_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .q_status (q_status)
   );

   bmm_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .q_status       (q_status),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_dest_index (rsp_dest_index),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_out_z      (rsp_out_z),
      .rsp_degenerate (rsp_degenerate),
      .rsp_saturated  (rsp_saturated)
   );

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && q_status.full))
      else $error("job pushed into a full queue");

   a_morph_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_command == CMD_MORPH) |=> busy)
      else $error("front end not busy after a morph request");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("pop from an empty queue");

endmodule

>>> sim/tb_barycentric_mesh_morph.sv
// Self-checking testbench for the barycentric mesh morph block.
`timescale 1ns / 100ps

module tb_barycentric_mesh_morph;
   import bmm_pkg::*;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_CYCLES = 250;
   localparam int RANDOM_ITEMS = 830;
   localparam longint COORD_MAX = 64'sh7FFFFFFF;
   localparam longint COORD_MIN = -64'sh80000000;

   typedef struct {
      logic                cmd;
      logic [IDX_BITS-1:0] target;
      coord_type           px, py, pz;
      coord_type           w0, w1, w2, d;
      logic [IDX_BITS-1:0] sa, sb, sc;
   } request_type;

   typedef struct {
      logic [IDX_BITS-1:0] dest;
      coord_type           x, y, z;
      logic                degen;
      logic                sat;
   } morph_result_type;

   typedef struct {
      request_type      req;
      bit               typed;
      morph_result_type res;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_command = CMD_LOAD;
   logic [IDX_BITS-1:0] req_target_index = '0;
   coord_type           req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   coord_type           req_weight_zero = '0, req_weight_one = '0, req_weight_two = '0;
   coord_type           req_normal_offset = '0;
   logic [IDX_BITS-1:0] req_src_a = '0, req_src_b = '0, req_src_c = '0;
   logic                rsp_valid;
   logic [IDX_BITS-1:0] rsp_dest_index;
   coord_type           rsp_out_x, rsp_out_y, rsp_out_z;
   logic                rsp_degenerate, rsp_saturated;

   coord_type vert_x [LOW_VERTS];
   coord_type vert_y [LOW_VERTS];
   coord_type vert_z [LOW_VERTS];
   bit        slot_written [LOW_VERTS];
   int        written_slots [$];

   morph_result_type pending_morphs [$];
   stim_row_type     directed_rows [$];
   int               errors = 0;
   int               cycles = 0;

   barycentric_mesh_morph dut (
      .clock, .reset, .start, .busy,
      .req_command, .req_target_index,
      .req_pos_x, .req_pos_y, .req_pos_z,
      .req_weight_zero, .req_weight_one, .req_weight_two, .req_normal_offset,
      .req_src_a, .req_src_b, .req_src_c,
      .rsp_valid, .rsp_dest_index, .rsp_out_x, .rsp_out_y, .rsp_out_z,
      .rsp_degenerate, .rsp_saturated
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("barycentric_mesh_morph: mismatch");
         $finish;
      end
   end

   task automatic report(input string what, input longint want, input longint got);
      $display("%0t: %s expected %0h got %0h", $realtime, what, want, got);
      errors++;
   endtask

   function automatic longint unsigned magnitude(input longint v);
      return v < 0 ? longint'(-v) : longint'(v);
   endfunction

   function automatic longint trunc_shift(input longint v, input int s);
      return v < 0 ? -longint'(magnitude(v) >> s) : longint'(magnitude(v) >> s);
   endfunction

   function automatic longint unsigned floor_root(input longint unsigned v);
      longint unsigned root = 0;
      longint unsigned bitpos = 64'd1 << 62;
      while (bitpos > v) bitpos >>= 2;
      while (bitpos != 0) begin
         if (v >= root + bitpos) begin
            v -= root + bitpos;
            root = (root >> 1) + bitpos;
         end else begin
            root >>= 1;
         end
         bitpos >>= 2;
      end
      return root;
   endfunction

   function automatic morph_result_type predict_morph(input request_type r);
      longint a[3], b[3], c[3], e1[3], e2[3], cr[3], n[3], w[3];
      longint unsigned m, sq, root, q;
      logic signed [127:0] acc, v;
      int s;
      morph_result_type res;
      a = '{vert_x[r.sa], vert_y[r.sa], vert_z[r.sa]};
      b = '{vert_x[r.sb], vert_y[r.sb], vert_z[r.sb]};
      c = '{vert_x[r.sc], vert_y[r.sc], vert_z[r.sc]};
      m = 0;
      for (int i = 0; i < 3; i++) begin
         e1[i] = a[i] - b[i];
         e2[i] = c[i] - b[i];
         if (magnitude(e1[i]) > m) m = magnitude(e1[i]);
         if (magnitude(e2[i]) > m) m = magnitude(e2[i]);
      end
      s = 0;
      while ((m >> s) >= (64'd1 << 30)) s++;
      for (int i = 0; i < 3; i++) begin
         e1[i] = trunc_shift(e1[i], s);
         e2[i] = trunc_shift(e2[i], s);
      end
      cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
      cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
      cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
      res.degen = (cr[0] == 0 && cr[1] == 0 && cr[2] == 0);
      n = '{0, 0, 0};
      if (!res.degen) begin
         m = 0;
         for (int i = 0; i < 3; i++)
            if (magnitude(cr[i]) > m) m = magnitude(cr[i]);
         s = 0;
         while ((m >> s) >= (64'd1 << 30)) s++;
         if (s > 0) begin
            for (int i = 0; i < 3; i++) cr[i] = trunc_shift(cr[i], s);
         end else begin
            while ((m << s) < (64'd1 << 29)) s++;
            for (int i = 0; i < 3; i++) cr[i] = cr[i] <<< s;
         end
         sq = 0;
         for (int i = 0; i < 3; i++) sq += magnitude(cr[i]) * magnitude(cr[i]);
         root = floor_root(sq);
         for (int i = 0; i < 3; i++) begin
            q = ((magnitude(cr[i]) << 16) + (root >> 1)) / root;
            n[i] = cr[i] < 0 ? -longint'(q) : longint'(q);
         end
      end
      res.sat = 1'b0;
      for (int i = 0; i < 3; i++) begin
         acc = 0;
         acc += longint'(r.w2) * a[i];
         acc += longint'(r.w1) * b[i];
         acc += longint'(r.w0) * c[i];
         acc += longint'(r.d) * n[i];
         // round half up back to Q16.16, then clamp
         v = (acc + 32768) >>> 16;
         if (v > COORD_MAX) begin
            v = COORD_MAX;
            res.sat = 1'b1;
         end
         if (v < COORD_MIN) begin
            v = COORD_MIN;
            res.sat = 1'b1;
         end
         w[i] = longint'(v);
      end
      res.dest = r.target;
      res.x = coord_type'(w[0]);
      res.y = coord_type'(w[1]);
      res.z = coord_type'(w[2]);
      return res;
   endfunction

   // Drive one request and hold it until accepted; update the store or queue the result.
   task automatic issue(input request_type r, input bit typed, input morph_result_type res);
      start <= 1'b1;
      req_command <= r.cmd;
      req_target_index <= r.target;
      req_pos_x <= r.px;
      req_pos_y <= r.py;
      req_pos_z <= r.pz;
      req_weight_zero <= r.w0;
      req_weight_one <= r.w1;
      req_weight_two <= r.w2;
      req_normal_offset <= r.d;
      req_src_a <= r.sa;
      req_src_b <= r.sb;
      req_src_c <= r.sc;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (r.cmd == CMD_LOAD) begin
         vert_x[r.target] = r.px;
         vert_y[r.target] = r.py;
         vert_z[r.target] = r.pz;
         if (!slot_written[r.target]) written_slots.push_back(r.target);
         slot_written[r.target] = 1'b1;
      end else begin
         pending_morphs.push_back(typed ? res : predict_morph(r));
      end
   endtask

   task automatic pause(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   function automatic request_type load_req(input int slot, input coord_type x,
                                            input coord_type y, input coord_type z);
      request_type r = '{default: '0};
      r.cmd = CMD_LOAD;
      r.target = IDX_BITS'(slot);
      r.px = x; r.py = y; r.pz = z;
      return r;
   endfunction

   function automatic request_type morph_req(input int dest, input int sa, input int sb,
                                             input int sc, input coord_type w0,
                                             input coord_type w1, input coord_type w2,
                                             input coord_type d);
      request_type r = '{default: '0};
      r.cmd = CMD_MORPH;
      r.target = IDX_BITS'(dest);
      r.sa = IDX_BITS'(sa); r.sb = IDX_BITS'(sb); r.sc = IDX_BITS'(sc);
      r.w0 = w0; r.w1 = w1; r.w2 = w2; r.d = d;
      return r;
   endfunction

   function automatic coord_type random_coord();
      case ($urandom_range(0, 4))
         0: return coord_type'($urandom);
         1: return coord_type'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
         2: return coord_type'($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
         3: case ($urandom_range(0, 3))
               0: return 32'sh7FFF_FFFF;
               1: return 32'sh8000_0000;
               2: return 32'sh0;
               default: return 32'shFFFF_FFFF;
            endcase
         default: return coord_type'($urandom) >>> $urandom_range(0, 31);
      endcase
   endfunction

   function automatic request_type random_request();
      request_type r;
      coord_type u, v;
      if (written_slots.size() < 3 || $urandom_range(0, 99) < 35) begin
         r = load_req($urandom_range(0, LOW_VERTS - 1), random_coord(), random_coord(),
                      random_coord());
      end else begin
         r = morph_req($urandom_range(0, LOW_VERTS - 1),
                       written_slots[$urandom_range(0, written_slots.size() - 1)],
                       written_slots[$urandom_range(0, written_slots.size() - 1)],
                       written_slots[$urandom_range(0, written_slots.size() - 1)],
                       0, 0, 0, random_coord());
         // repeat a source now and then to force a flat triangle
         if ($urandom_range(0, 9) == 0) r.sc = r.sa;
         if ($urandom_range(0, 1) == 0) begin
            u = $urandom_range(0, 32'h10000);
            v = $urandom_range(0, 32'h10000 - u);
            r.w0 = u;
            r.w1 = v;
            r.w2 = 32'sh10000 - u - v;
         end else begin
            r.w0 = random_coord();
            r.w1 = random_coord();
            r.w2 = random_coord();
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      morph_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_morphs.size() == 0) begin
            report("unexpected result, dest", 0, rsp_dest_index);
         end else begin
            want = pending_morphs.pop_front();
            if (rsp_dest_index !== want.dest) report("dest_index", want.dest, rsp_dest_index);
            if (rsp_out_x !== want.x) report("out_x", want.x, rsp_out_x);
            if (rsp_out_y !== want.y) report("out_y", want.y, rsp_out_y);
            if (rsp_out_z !== want.z) report("out_z", want.z, rsp_out_z);
            if (rsp_degenerate !== want.degen)
               report("degenerate", want.degen, rsp_degenerate);
            if (rsp_saturated !== want.sat) report("saturated", want.sat, rsp_saturated);
         end
      end
   end

   initial begin
      stim_row_type row;
      request_type r;
      int burst;
      localparam coord_type CMAX = 32'sh7FFF_FFFF;
      localparam coord_type CMIN = 32'sh8000_0000;

      directed_rows.push_back('{load_req(0, 0, 0, 0), 0, '{default: '0}});
      directed_rows.push_back('{load_req(1, CMAX, CMAX, CMAX), 0, '{default: '0}});
      directed_rows.push_back('{load_req(2, CMIN, CMIN, CMIN), 0, '{default: '0}});
      directed_rows.push_back('{load_req(3, 32'sh10000, 0, 0), 0, '{default: '0}});
      directed_rows.push_back('{load_req(4, 0, 32'sh10000, 0), 0, '{default: '0}});
      directed_rows.push_back('{load_req(4095, CMIN, CMAX, 32'sh1234_5678), 0,
                                '{default: '0}});
      // flat triangle at the origin: normal forced to zero
      directed_rows.push_back('{morph_req(4095, 0, 0, 0, CMAX, CMIN, CMAX, CMAX), 1,
                                '{12'd4095, 0, 0, 0, 1'b1, 1'b0}});
      directed_rows.push_back('{morph_req(7, 1, 1, 1, 0, 0, CMAX, 0), 1,
                                '{12'd7, CMAX, CMAX, CMAX, 1'b1, 1'b1}});
      directed_rows.push_back('{morph_req(8, 1, 1, 1, 0, 0, CMIN, 0), 1,
                                '{12'd8, CMIN, CMIN, CMIN, 1'b1, 1'b1}});
      // unit triangle in the xy plane: normal is +z
      directed_rows.push_back('{morph_req(9, 3, 0, 4, 0, 0, 0, 32'sh10000), 1,
                                '{12'd9, 0, 0, 32'sh10000, 1'b0, 1'b0}});
      directed_rows.push_back('{morph_req(10, 3, 0, 4, 0, 0, 0, CMIN), 0, '{default: '0}});
      directed_rows.push_back('{morph_req(11, 4, 0, 3, 32'sh8000, 32'sh8000, 0, CMAX), 0,
                                '{default: '0}});
      directed_rows.push_back('{morph_req(12, 1, 2, 4095, 32'sh5555, 32'sh5555, 32'sh5556,
                                          32'sh10000), 0, '{default: '0}});
      directed_rows.push_back('{morph_req(13, 2, 1, 0, 32'sh10000, 0, 0, CMAX), 0,
                                '{default: '0}});
      directed_rows.push_back('{morph_req(14, 4095, 3, 1, CMIN, CMAX, 32'shFFFF_FFFF,
                                          32'sh1), 0, '{default: '0}});
      directed_rows.push_back('{morph_req(15, 3, 4, 4095, 32'shFFFF_0000, 32'sh2_0000,
                                          32'sh0, CMIN), 0, '{default: '0}});
      directed_rows.push_back('{morph_req(16, 2, 4095, 1, 32'sh1, 32'sh1, 32'sh1, CMAX), 0,
                                '{default: '0}});
      directed_rows.push_back('{load_req(1, 32'sh1, 32'sh0, CMIN), 0, '{default: '0}});
      directed_rows.push_back('{morph_req(17, 1, 0, 4, 32'sh10000, 32'sh10000, 32'sh10000,
                                          32'sh10000), 0, '{default: '0}});

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         issue(row.req, row.typed, row.res);
      end
      // hold off until every queued morph has come back
      start <= 1'b0;
      while (pending_morphs.size() != 0) @(posedge clock);

      for (int sent = 0; sent < RANDOM_ITEMS; ) begin
         burst = $urandom_range(1, 24);
         for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
            r = random_request();
            issue(r, 1'b0, '{default: '0});
            sent++;
            // advance without a gap inside a burst most of the time
            if ($urandom_range(0, 7) == 0) pause($urandom_range(1, 3));
         end
         if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 200));
      end
      start <= 1'b0;

      while (pending_morphs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_morphs.size() != 0) report("results left over", 0, pending_morphs.size());
      if (errors == 0) begin
         $display("barycentric_mesh_morph: match");
      end else begin
         $display("barycentric_mesh_morph: mismatch");
      end
      $finish;
   end

endmodule
